// ===== sv/mfh_pkg.sv =====
// ----------------------------------------------------------------------------
// mfh_pkg: shared types and codes for the recursive mutex
// Opcodes, status codes, field widths and the controller command bundle.
// ----------------------------------------------------------------------------
package mfh_pkg;

  localparam int TASK_ID_W    = 4;
  localparam int HOLD_COUNT_W = 8;
  localparam int STATUS_W     = 3;

  typedef enum logic {
    OP_LOCK   = 1'b0,
    OP_UNLOCK = 1'b1
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED    = 3'd0,
    ST_RECURSED   = 3'd1,
    ST_QUEUED     = 3'd2,
    ST_QFULL      = 3'd3,
    ST_SATURATED  = 3'd4,
    ST_STILL_HELD = 3'd5,
    ST_FREED      = 3'd6,
    ST_NOT_OWNER  = 3'd7
  } status_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;  // latch the accepted request
    logic commit;   // apply the request and load the result register
  } ctrl_cmd_t;

endpackage

// ===== sv/mfh_if.sv =====
// ----------------------------------------------------------------------------
// mfh_if: request and result channels
// Valid/ready channels carrying the lock requests and their results.
// ----------------------------------------------------------------------------
interface mfh_req_if;
  logic                           valid;
  logic                           ready;
  logic                           opcode;
  logic [mfh_pkg::TASK_ID_W-1:0]  task_id;

  modport source (output valid, output opcode, output task_id, input ready);
  modport sink   (input valid, input opcode, input task_id, output ready);
endinterface

interface mfh_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [mfh_pkg::STATUS_W-1:0]     status;
  logic                             woken_valid;
  logic [mfh_pkg::TASK_ID_W-1:0]    woken_task;
  logic                             owner_valid;
  logic [mfh_pkg::TASK_ID_W-1:0]    owner_task;
  logic [mfh_pkg::HOLD_COUNT_W-1:0] hold_count;

  modport source (output valid, output status, output woken_valid, output woken_task,
                  output owner_valid, output owner_task, output hold_count, input ready);
  modport sink   (input valid, input status, input woken_valid, input woken_task,
                  input owner_valid, input owner_task, input hold_count, output ready);
endinterface

// ===== sv/mfh_ram.sv =====
// ----------------------------------------------------------------------------
// mfh_ram: generic single-port-write RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mfh_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                     wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/mfh_ctrl.sv =====
// ----------------------------------------------------------------------------
// mfh_ctrl: request sequencer
// Takes one request, waits for a free result slot, then commits it.
// ----------------------------------------------------------------------------
module mfh_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output mfh_pkg::ctrl_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;
  logic   slot_free;

  assign slot_free   = !rsp_valid || rsp_ready;
  assign req_ready   = (state == S_IDLE) && !rst;
  assign cmd.capture = req_valid && req_ready;
  assign cmd.commit  = (state == S_EXEC) && slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.capture) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (cmd.commit) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/mfh_dp.sv =====
// ----------------------------------------------------------------------------
// mfh_dp: mutex datapath
// Owner, hold count, wait ring pointers and the result register.
// ----------------------------------------------------------------------------
module mfh_dp #(
  parameter int QUEUE_DEPTH = 16,
  parameter int HOLD_MAX    = 255
) (
  input  logic                             clk,
  input  logic                             rst,
  input  mfh_pkg::ctrl_cmd_t               cmd,
  input  logic                             req_opcode,
  input  logic [mfh_pkg::TASK_ID_W-1:0]    req_task_id,
  output logic [mfh_pkg::STATUS_W-1:0]     status,
  output logic                             woken_valid,
  output logic [mfh_pkg::TASK_ID_W-1:0]    woken_task,
  output logic                             owner_valid,
  output logic [mfh_pkg::TASK_ID_W-1:0]    owner_task,
  output logic [mfh_pkg::HOLD_COUNT_W-1:0] hold_count
);

  localparam int TW = mfh_pkg::TASK_ID_W;
  localparam int CW = mfh_pkg::HOLD_COUNT_W;
  localparam int HW = $clog2(HOLD_MAX + 1);
  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [HW-1:0] HOLD_TOP  = HW'(HOLD_MAX);
  localparam logic [HW-1:0] HOLD_ONE  = HW'(1);
  localparam logic [FW-1:0] FILL_FULL = FW'(QUEUE_DEPTH);
  localparam logic [PW-1:0] PTR_LAST  = PW'(QUEUE_DEPTH - 1);

  mfh_pkg::opcode_t op_q;
  logic [TW-1:0]    tid_q;

  logic [HW-1:0] hold, hold_next;
  logic [TW-1:0] owner, owner_next;
  logic [PW-1:0] head, head_next, tail, tail_next;
  logic [FW-1:0] fill, fill_next;

  mfh_pkg::status_t st;
  logic             woke, push;
  logic [TW-1:0]    head_task;
  logic [HW+CW-1:0] hold_wide;

  // Wait ring: read address follows the head, so the registered head entry
  // is ready by the time a taken request commits.
  mfh_ram #(
    .WIDTH (TW),
    .DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (cmd.commit && push),
    .wr_addr (tail),
    .wr_data (tid_q),
    .rd_addr (head),
    .rd_data (head_task)
  );

  always_comb begin
    hold_next  = hold;
    owner_next = owner;
    head_next  = head;
    tail_next  = tail;
    fill_next  = fill;
    st         = mfh_pkg::ST_NOT_OWNER;
    woke       = 1'b0;
    push       = 1'b0;
    case (op_q)
      mfh_pkg::OP_LOCK: begin
        if (hold == '0) begin
          hold_next  = HOLD_ONE;
          owner_next = tid_q;
          st         = mfh_pkg::ST_GRANTED;
        end else if (owner == tid_q) begin
          if (hold == HOLD_TOP) begin
            st = mfh_pkg::ST_SATURATED;
          end else begin
            hold_next = hold + HOLD_ONE;
            st        = mfh_pkg::ST_RECURSED;
          end
        end else if (fill == FILL_FULL) begin
          st = mfh_pkg::ST_QFULL;
        end else begin
          push      = 1'b1;
          tail_next = (tail == PTR_LAST) ? '0 : tail + PW'(1);
          fill_next = fill + FW'(1);
          st        = mfh_pkg::ST_QUEUED;
        end
      end
      mfh_pkg::OP_UNLOCK: begin
        if (hold == '0 || owner != tid_q) begin
          st = mfh_pkg::ST_NOT_OWNER;
        end else if (hold != HOLD_ONE) begin
          hold_next = hold - HOLD_ONE;
          st        = mfh_pkg::ST_STILL_HELD;
        end else begin
          st         = mfh_pkg::ST_FREED;
          hold_next  = '0;
          owner_next = '0;
          if (fill != '0) begin
            woke       = 1'b1;
            owner_next = head_task;
            hold_next  = HOLD_ONE;
            head_next  = (head == PTR_LAST) ? '0 : head + PW'(1);
            fill_next  = fill - FW'(1);
          end
        end
      end
      default: begin
        st = mfh_pkg::ST_NOT_OWNER;
      end
    endcase
  end

  assign hold_wide = {{CW{1'b0}}, hold_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      hold  <= '0;
      owner <= '0;
      head  <= '0;
      tail  <= '0;
      fill  <= '0;
    end else if (cmd.commit) begin
      hold  <= hold_next;
      owner <= owner_next;
      head  <= head_next;
      tail  <= tail_next;
      fill  <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q  <= mfh_pkg::opcode_t'(req_opcode);
      tid_q <= req_task_id;
    end
    if (cmd.commit) begin
      status      <= st;
      woken_valid <= woke;
      woken_task  <= woke ? head_task : '0;
      owner_valid <= (hold_next != '0);
      owner_task  <= (hold_next != '0) ? owner_next : '0;
      hold_count  <= hold_wide[CW-1:0];
    end
  end

endmodule

// ===== sv/recursive_mutex_fifo_handoff_top.sv =====
// ----------------------------------------------------------------------------
// recursive_mutex_fifo_handoff_top: recursive mutex with a FIFO wait queue
// Lock/unlock requests in, one result per request out.
// ----------------------------------------------------------------------------
// Usage:
//   req : valid/ready channel carrying opcode (lock or unlock) and task_id.
//   rsp : valid/ready channel carrying status, the woken task, the owner and
//         the hold count after the request.
//   Every request yields exactly one result, in request order.
// Sequencing:
//   A request is taken in S_IDLE and committed from S_EXEC once the result
//   slot is free, so a new request is taken only after the last one has
//   committed. The result is registered on rsp. S_EXEC also covers the
//   registered read of the wait ring, which is addressed by the queue head.
// Reset (rst, synchronous, active high):
//   The mutex is free, the queue is empty and no result is pending. The wait
//   ring itself is not cleared; an entry is only read once it was written.
// Back-pressure:
//   A finished result is held on rsp while the receiver stalls; a following
//   request is still taken and then waits, uncommitted, until the slot frees.
// ----------------------------------------------------------------------------
module recursive_mutex_fifo_handoff_top #(
  parameter int QUEUE_DEPTH = 16,
  parameter int HOLD_MAX    = 255
) (
  input logic       clk,
  input logic       rst,
  mfh_req_if.sink   req,
  mfh_rsp_if.source rsp
);

  mfh_pkg::ctrl_cmd_t cmd;

  // Sequencer: owns the handshakes and decides when a request commits
  mfh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  // Datapath: mutex state, wait ring and result register
  mfh_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .HOLD_MAX    (HOLD_MAX)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .req_opcode  (req.opcode),
    .req_task_id (req.task_id),
    .status      (rsp.status),
    .woken_valid (rsp.woken_valid),
    .woken_task  (rsp.woken_task),
    .owner_valid (rsp.owner_valid),
    .owner_task  (rsp.owner_task),
    .hold_count  (rsp.hold_count)
  );

`ifndef SYNTHESIS
  // A handoff always makes the woken task the owner with a single hold
  a_handoff_owner: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.woken_valid |->
      rsp.status == mfh_pkg::ST_FREED && rsp.owner_valid &&
      rsp.owner_task == rsp.woken_task && rsp.hold_count == 8'd1)
    else $error("handoff result inconsistent");

  // A free mutex reports no owner
  a_free_no_owner: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.owner_valid |->
      rsp.owner_task == '0 && !rsp.woken_valid)
    else $error("free mutex reports an owner");

  // One request in flight: nothing is taken in the cycle after a request
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request taken while another is in flight");
`endif

endmodule
